/* rtl/packed_24bit_number_codec_core_macros.svh */
// Assertion macros used by the codec core.
`ifndef PACKED_24BIT_NUMBER_CODEC_CORE_MACROS_SVH
`define PACKED_24BIT_NUMBER_CODEC_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define PC_ASSERT_IMPL(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("codec assertion failed");
// Next-cycle implication, checked out of reset.
`define PC_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("codec assertion failed");
`else
`define PC_ASSERT_IMPL(lbl, a, b)
`define PC_ASSERT_NEXT(lbl, a, b)
`endif
`endif

/* rtl/pcodec_pkg.sv */
// Types and constants shared by the packed number codec.
package pcodec_pkg;

    typedef enum logic [1:0] {
        ACT_PACK_F24    = 2'd0,
        ACT_UNPACK_F24  = 2'd1,
        ACT_PACK_FR24   = 2'd2,
        ACT_UNPACK_FR24 = 2'd3
    } action_t;

    // Load enables of the three inner pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    localparam logic [13:0] FR_SCALE   = 14'd10000;
    // Significand of the double nearest 1/10000 (value = RECIP_MANT * 2^-66)
    localparam logic [52:0] RECIP_MANT = 53'h1A36E2EB1C432D;

endpackage

/* rtl/packed_24bit_number_codec_core.sv */
// Top level of the packed 24-bit number codec: handshake, float24 path, output register.
// Pipeline: three inner stages plus the output register lie between input acceptance and m_tvalid.
// Throughput: one item per cycle while m_tready holds; each stage loads whenever it is empty or its item moves on.
// The slowest stage holds one 27x14 or 27x23 multiply, or a 76-bit add.
// Reset clears every stage valid bit and so empties the pipeline; data registers keep no reset.
module packed_24bit_number_codec_core
    import pcodec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value_bits[63:0]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // result_bits[63:0]
    output logic        m_tuser    // ok
);

`include "packed_24bit_number_codec_core_macros.svh"

    stage_en_t en;
    logic      load_out;

    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic v1_next, v2_next, v3_next, vo_next;

    action_t act_in;
    action_t act1_reg, act2_reg, act3_reg, acto_reg;

    // float24 path: resolved at entry, then delayed alongside the item
    logic [31:0] f32;
    logic [23:0] f24w;
    logic [7:0]  fe;
    logic [5:0]  ne, r6;
    logic [16:0] nm;
    logic [17:0] nsum;
    logic        rup;
    logic [63:0] fres;
    logic        fok;

    logic [63:0] fres1_reg, fres2_reg, fres3_reg;
    logic        fok1_reg, fok2_reg, fok3_reg;

    logic [63:0] pack_res, unpack_res;
    logic        pack_ok;

    logic [63:0] res_o_reg, res_o_next;
    logic        ok_o_reg, ok_o_next;

    // Ready ripples back: a stage loads when empty or when its item advances
    assign load_out = !vo_reg || m_tready;
    assign en.s3    = !v3_reg || load_out;
    assign en.s2    = !v2_reg || en.s3;
    assign en.s1    = !v1_reg || en.s2;
    assign s_tready = en.s1;

    assign v1_next = en.s1 ? s_tvalid : v1_reg;
    assign v2_next = en.s2 ? v1_reg : v2_reg;
    assign v3_next = en.s3 ? v2_reg : v3_reg;
    assign vo_next = load_out ? v3_reg : vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            vo_reg <= vo_next;
        end
    end

    assign act_in = action_t'(s_tuser);
    assign f32    = s_tdata[31:0];
    assign f24w   = s_tdata[23:0];

    // Pack float24 (rebias, round the six dropped bits to nearest even), or unpack float24
    always_comb
    begin
        fe   = f32[30:23];
        ne   = 6'(fe - 8'd96);
        r6   = f32[5:0];
        nm   = f32[22:6];
        rup  = (r6 > 6'd32) || ((r6 == 6'd32) && nm[0]);
        nsum = {1'b0, nm} + {17'd0, rup};
        fres = 64'd0;
        fok  = 1'b1;
        case (act_in)
            ACT_PACK_F24:
            begin
                if (fe == 8'hFF)
                    fok = 1'b0;
                else if (fe == 8'd0)
                    fres = {40'd0, f32[31], 23'd0};
                else if (fe < 8'd97 || fe > 8'd159)
                    fok = 1'b0;
                else if (nsum[17])
                begin
                    // carry out of the fraction: bump the exponent
                    if (ne == 6'd63)
                        fok = 1'b0;
                    else
                        fres = {40'd0, f32[31], ne + 6'd1, 17'd0};
                end
                else
                    fres = {40'd0, f32[31], ne, nsum[16:0]};
            end
            ACT_UNPACK_F24:
            begin
                if (f24w[22:17] == 6'd0)
                    fres = {32'd0, f24w[23], 31'd0};
                else
                    fres = {32'd0, f24w[23], {2'b00, f24w[22:17]} + 8'd96, f24w[16:0], 6'd0};
            end
            default:
            begin
                fres = 64'd0;
                fok  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            act1_reg  <= act_in;
            fres1_reg <= fres;
            fok1_reg  <= fok;
        end
        if (en.s2)
        begin
            act2_reg  <= act1_reg;
            fres2_reg <= fres1_reg;
            fok2_reg  <= fok1_reg;
        end
        if (en.s3)
        begin
            act3_reg  <= act2_reg;
            fres3_reg <= fres2_reg;
            fok3_reg  <= fok2_reg;
        end
    end

    pcodec_frpack u_frpack (
        .clk         (clk),
        .en          (en),
        .value_bits  (s_tdata),
        .result_bits (pack_res),
        .ok          (pack_ok)
    );

    pcodec_frunpack u_frunpack (
        .clk         (clk),
        .en          (en),
        .word        (f24w),
        .result_bits (unpack_res)
    );

    // Select the finished result by action
    always_comb
    begin
        case (act3_reg) inside
            ACT_PACK_F24, ACT_UNPACK_F24:
            begin
                res_o_next = fres3_reg;
                ok_o_next  = fok3_reg;
            end
            ACT_PACK_FR24:
            begin
                res_o_next = pack_res;
                ok_o_next  = pack_ok;
            end
            default:
            begin
                res_o_next = unpack_res;
                ok_o_next  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            res_o_reg <= res_o_next;
            ok_o_reg  <= ok_o_next;
            acto_reg  <= act3_reg;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = res_o_reg;
    assign m_tuser  = ok_o_reg;

    `PC_ASSERT_IMPL(a_reject_zero, m_tvalid && !m_tuser, m_tdata == 64'd0)
    `PC_ASSERT_IMPL(a_unpack_ok,
        m_tvalid && (acto_reg == ACT_UNPACK_F24 || acto_reg == ACT_UNPACK_FR24), m_tuser)
    `PC_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, v1_reg)
    `PC_ASSERT_NEXT(a_stall_holds, v3_reg && vo_reg && !m_tready, v3_reg && vo_reg)

endmodule

/* rtl/pcodec_frpack.sv */
// Pipelined double to fract24 packer: magnitude times 10000, rounded, floored.
module pcodec_frpack
    import pcodec_pkg::*;
(
    input  logic        clk,
    input  stage_en_t   en,
    input  logic [63:0] value_bits,
    output logic [63:0] result_bits,
    output logic        ok
);

    logic [10:0] exp_in;
    logic [52:0] man_in;

    logic [40:0] pa1_reg, pa1_next;
    logic [39:0] pb1_reg, pb1_next;
    logic [10:0] e1_reg;
    logic        norm1_reg, sgn1_reg, bad1_reg;

    logic [66:0] q2_reg, q2_next;
    logic [10:0] e2_reg;
    logic        norm2_reg, sgn2_reg, bad2_reg;

    logic               top;
    logic [52:0]        kept;
    logic               guard, sticky, rup;
    logic [53:0]        r3_reg, r3_next;
    logic signed [12:0] sh3_reg, sh3_next;
    logic               sgn3_reg, bad3_reg;

    logic [53:0] qf;
    logic        big;

    assign exp_in   = value_bits[62:52];
    assign man_in   = {exp_in != 11'd0, value_bits[51:0]};
    assign pa1_next = {14'd0, man_in[52:26]} * {27'd0, FR_SCALE};
    assign pb1_next = {14'd0, man_in[25:0]} * {26'd0, FR_SCALE};

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            pa1_reg   <= pa1_next;
            pb1_reg   <= pb1_next;
            e1_reg    <= (exp_in == 11'd0) ? 11'd1 : exp_in;
            norm1_reg <= exp_in != 11'd0;
            // minus zero keeps a clear sign, a negative denormal does not
            sgn1_reg  <= value_bits[63] && (value_bits[62:0] != 63'd0);
            bad1_reg  <= (exp_in == 11'h7FF) && (value_bits[51:0] != 52'd0);
        end
    end

    assign q2_next = {pa1_reg, 26'd0} + {27'd0, pb1_reg};

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            q2_reg    <= q2_next;
            e2_reg    <= e1_reg;
            norm2_reg <= norm1_reg;
            sgn2_reg  <= sgn1_reg;
            bad2_reg  <= bad1_reg;
        end
    end

    // Round the exact product to 53 significant bits, ties to even
    always_comb
    begin
        top     = q2_reg[66];
        kept    = top ? q2_reg[66:14] : q2_reg[65:13];
        guard   = top ? q2_reg[13] : q2_reg[12];
        sticky  = top ? (q2_reg[12:0] != 13'd0) : (q2_reg[11:0] != 12'd0);
        rup     = guard && (sticky || kept[0]);
        r3_next = norm2_reg ? ({1'b0, kept} + {53'd0, rup}) : 54'd0;
        sh3_next = 13'sd1075 - $signed({2'b00, e2_reg}) - (top ? 13'sd14 : 13'sd13);
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            r3_reg   <= r3_next;
            sh3_reg  <= sh3_next;
            sgn3_reg <= sgn2_reg;
            bad3_reg <= bad2_reg;
        end
    end

    // Floor: drop the bits below the binary point
    always_comb
    begin
        if (sh3_reg <= 13'sd0)
        begin
            qf  = 54'd0;
            big = r3_reg != 54'd0;
        end
        else if (sh3_reg >= 13'sd54)
        begin
            qf  = 54'd0;
            big = 1'b0;
        end
        else
        begin
            qf  = r3_reg >> sh3_reg[5:0];
            big = qf[53:23] != 31'd0;
        end
        ok          = !bad3_reg && !big;
        result_bits = ok ? {40'd0, sgn3_reg, qf[22:0]} : 64'd0;
    end

endmodule

/* rtl/pcodec_frunpack.sv */
// Pipelined fract24 to double unpacker: magnitude times the double nearest 1/10000.
module pcodec_frunpack
    import pcodec_pkg::*;
(
    input  logic        clk,
    input  stage_en_t   en,
    input  logic [23:0] word,
    output logic [63:0] result_bits
);

    logic [22:0] mag_in;
    logic [4:0]  lead_in;

    logic [49:0] qa1_reg, qa1_next;
    logic [48:0] qb1_reg, qb1_next;
    logic [4:0]  nl1_reg;
    logic        nz1_reg, sgn1_reg;

    logic [75:0] p2_reg, p2_next;
    logic [4:0]  nl2_reg;
    logic        nz2_reg, sgn2_reg;

    logic [75:0] pn3_reg, pn3_next;
    logic [4:0]  nl3_reg;
    logic        nz3_reg, sgn3_reg;

    logic        top, guard, sticky, rup;
    logic [52:0] kept;
    logic [53:0] r;
    logic [6:0]  tpos;
    logic [10:0] exp_out;

    assign mag_in = word[22:0];

    always_comb
    begin
        lead_in = 5'd0;
        for (int i = 0; i < 23; i++)
        begin
            if (mag_in[i])
                lead_in = 5'(i);
        end
    end

    assign qa1_next = {23'd0, RECIP_MANT[52:26]} * {27'd0, mag_in};
    assign qb1_next = {23'd0, RECIP_MANT[25:0]} * {26'd0, mag_in};

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            qa1_reg  <= qa1_next;
            qb1_reg  <= qb1_next;
            nl1_reg  <= lead_in;
            nz1_reg  <= mag_in != 23'd0;
            sgn1_reg <= word[23];
        end
    end

    assign p2_next = {qa1_reg, 26'd0} + {27'd0, qb1_reg};

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            p2_reg   <= p2_next;
            nl2_reg  <= nl1_reg;
            nz2_reg  <= nz1_reg;
            sgn2_reg <= sgn1_reg;
        end
    end

    // Normalise: the leading one lands in bit 75 or bit 74
    assign pn3_next = p2_reg << (5'd22 - nl2_reg);

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            pn3_reg  <= pn3_next;
            nl3_reg  <= nl2_reg;
            nz3_reg  <= nz2_reg;
            sgn3_reg <= sgn2_reg;
        end
    end

    always_comb
    begin
        top     = pn3_reg[75];
        kept    = top ? pn3_reg[75:23] : pn3_reg[74:22];
        guard   = top ? pn3_reg[22] : pn3_reg[21];
        sticky  = top ? (pn3_reg[21:0] != 22'd0) : (pn3_reg[20:0] != 21'd0);
        rup     = guard && (sticky || kept[0]);
        r       = {1'b0, kept} + {53'd0, rup};
        tpos    = {2'b00, nl3_reg} + (top ? 7'd53 : 7'd52);
        exp_out = {4'd0, tpos} + 11'd957 + {10'd0, r[53]};
        if (nz3_reg)
            result_bits = {sgn3_reg, exp_out, r[53] ? 52'd0 : r[51:0]};
        else
            result_bits = {sgn3_reg, 63'd0};
    end

endmodule
